// File: hw/rtl/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types, constants and the month-length lookup for the calendar
// time counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctc_pkg;

  // Field widths
  localparam int SecW   = 6;
  localparam int MinW   = 6;
  localparam int HourW  = 5;
  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 8;
  localparam int ModeW  = 2;

  // Rollover limits
  localparam logic [SecW:0]   SEC_LIMIT    = 7'd60;
  localparam logic [MinW:0]   MIN_LIMIT    = 7'd60;
  localparam logic [HourW:0]  HOUR_LIMIT   = 6'd24;
  localparam logic [MonthW:0] MONTH_LIMIT  = 5'd13;
  localparam logic [SecW-1:0] WAKE_SECONDS = 6'd45;

  // Operation codes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // Receiver mode codes
  typedef enum logic [ModeW-1:0] {
    MODE_OFF    = 2'd0,
    MODE_HOURLY = 2'd1,
    MODE_ON     = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  // Reset values of the calendar
  localparam logic [SecW-1:0]   RST_SEC   = 6'd0;
  localparam logic [MinW-1:0]   RST_MIN   = 6'd0;
  localparam logic [HourW-1:0]  RST_HOUR  = 5'd0;
  localparam logic [DayW-1:0]   RST_DAY   = 5'd1;
  localparam logic [MonthW-1:0] RST_MONTH = 4'd1;
  localparam logic [YearW-1:0]  RST_YEAR  = 8'd8;

  // Month lengths; month zero has none, months above twelve count as 31
  localparam logic [DayW-1:0] MONTH_LEN [16] = '{
    5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  // Days in the given month, February gets 29 in years divisible by four
  function automatic logic [DayW-1:0] days_in_month(
    input logic [MonthW-1:0] month,
    input logic [YearW-1:0]  year
  );
    logic [DayW-1:0] len;
    len = MONTH_LEN[month];
    if (month == 4'd2 && year[1:0] == 2'b00) begin
      len = 5'd29;
    end
    return len;
  endfunction

endpackage

// File: hw/rtl/calendar_time_counter.sv
// ----------------------------------------------------------------------------
// calendar_time_counter
// Real-time clock calendar: one-second ticks advance seconds through year
// with a carry cascade; a load writes the whole date and time, a hold keeps it.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  --------+-----------------------+---------------------------------------
//  input   | in_valid / in_ready   | op, hold, load_seconds .. load_year
//  result  | out_valid / out_ready | now_seconds .. now_year, wake_receiver
//  config  | cfg_valid / cfg_ready | cfg_data (receiver mode)
//
//  One transaction per cycle unless the result is stalled: the carry cascade
//  runs in the accept cycle and the result lands in the output register.
//  in_ready is high while the output register is empty or being drained.
//  Synchronous reset sets 2008-01-01 00:00:00, receiver mode always on.
//  A stalled result holds its payload; cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_time_counter
  import ctc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ModeW-1:0]  cfg_data,
  // input transactions
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic              hold,
  input  logic [SecW-1:0]   load_seconds,
  input  logic [MinW-1:0]   load_minutes,
  input  logic [HourW-1:0]  load_hours,
  input  logic [DayW-1:0]   load_day,
  input  logic [MonthW-1:0] load_month,
  input  logic [YearW-1:0]  load_year,
  // result transactions
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SecW-1:0]   now_seconds,
  output logic [MinW-1:0]   now_minutes,
  output logic [HourW-1:0]  now_hours,
  output logic [DayW-1:0]   now_day,
  output logic [MonthW-1:0] now_month,
  output logic [YearW-1:0]  now_year,
  output logic              wake_receiver
);

  logic [ModeW-1:0]  receiver_mode;
  logic [SecW-1:0]   sec_count,   sec_count_next;
  logic [MinW-1:0]   min_count,   min_count_next;
  logic [HourW-1:0]  hour_count,  hour_count_next;
  logic [DayW-1:0]   day_count,   day_count_next;
  logic [MonthW-1:0] month_count, month_count_next;
  logic [YearW-1:0]  year_count,  year_count_next;
  logic              wake_next;
  logic              in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      receiver_mode <= MODE_ON;
    end else if (cfg_valid) begin
      receiver_mode <= cfg_data;
    end
  end

  // Next calendar state: load, hold or carry cascade
  always_comb begin
    logic [SecW:0]   s;
    logic [MinW:0]   m;
    logic [HourW:0]  h;
    logic [DayW:0]   d;
    logic [MonthW:0] mo;
    logic [YearW:0]  y;
    logic [DayW:0]   len_plus;

    // cascade, checks made on every advancing tick with unclipped values
    s  = {1'b0, sec_count} + 7'd1;
    m  = {1'b0, min_count};
    h  = {1'b0, hour_count};
    d  = {1'b0, day_count};
    mo = {1'b0, month_count};
    y  = {1'b0, year_count};
    len_plus = {1'b0, days_in_month(month_count, year_count)} + 6'd1;
    if (s >= SEC_LIMIT) begin
      s = '0;
      m = m + 7'd1;
    end
    if (m >= MIN_LIMIT) begin
      m = '0;
      h = h + 6'd1;
    end
    if (h >= HOUR_LIMIT) begin
      h = '0;
      d = d + 6'd1;
    end
    if (d >= len_plus) begin
      d  = 6'd1;
      mo = mo + 5'd1;
    end
    if (mo >= MONTH_LIMIT) begin
      mo = 5'd1;
      y  = y + 9'd1;
    end

    if (op_t'(op) == OP_LOAD) begin
      sec_count_next   = load_seconds;
      min_count_next   = load_minutes;
      hour_count_next  = load_hours;
      day_count_next   = load_day;
      month_count_next = load_month;
      year_count_next  = load_year;
    end else if (hold) begin
      sec_count_next   = sec_count;
      min_count_next   = min_count;
      hour_count_next  = hour_count;
      day_count_next   = day_count;
      month_count_next = month_count;
      year_count_next  = year_count;
    end else begin
      sec_count_next   = s[SecW-1:0];
      min_count_next   = m[MinW-1:0];
      hour_count_next  = h[HourW-1:0];
      day_count_next   = d[DayW-1:0];
      month_count_next = mo[MonthW-1:0];
      year_count_next  = y[YearW-1:0];
    end

    // wake flag on the time after the step
    wake_next = (mode_t'(receiver_mode) == MODE_HOURLY) &&
                (min_count_next == '0) && (sec_count_next >= WAKE_SECONDS);
  end

  // Calendar state
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_count   <= RST_SEC;
      min_count   <= RST_MIN;
      hour_count  <= RST_HOUR;
      day_count   <= RST_DAY;
      month_count <= RST_MONTH;
      year_count  <= RST_YEAR;
    end else if (in_accept) begin
      sec_count   <= sec_count_next;
      min_count   <= min_count_next;
      hour_count  <= hour_count_next;
      day_count   <= day_count_next;
      month_count <= month_count_next;
      year_count  <= year_count_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      now_seconds   <= sec_count_next;
      now_minutes   <= min_count_next;
      now_hours     <= hour_count_next;
      now_day       <= day_count_next;
      now_month     <= month_count_next;
      now_year      <= year_count_next;
      wake_receiver <= wake_next;
    end
  end

endmodule

// File: hw/rtl/ctc_checker.sv
// ----------------------------------------------------------------------------
// ctc_checker
// Port-level checks for the calendar time counter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctc_checker
  import ctc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SecW-1:0]   now_seconds,
  input logic [MinW-1:0]   now_minutes,
  input logic              wake_receiver
);

  // Every accepted transaction shows a result in the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");

  // A stalled result keeps its time
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(now_seconds) &&
      $stable(now_minutes) && $stable(wake_receiver))
    else $error("stalled result changed");

  // Wake flag only in the last quarter of the first minute of the hour
  a_wake_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && wake_receiver |-> now_minutes == '0 &&
      now_seconds >= WAKE_SECONDS)
    else $error("wake flag outside its window");

  // Input is taken whenever the output side is free
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with output free");

endmodule

bind calendar_time_counter ctc_checker u_ctc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .now_seconds   (now_seconds),
  .now_minutes   (now_minutes),
  .wake_receiver (wake_receiver)
);
